// ===== src/ffpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ffpa_pkg;

	localparam int MEM_WORDS_DEF  = 1024;
	localparam int TABLE_ROWS_DEF = 256;
	// compare width: holds any 16-bit request or address and MEM_WORDS itself
	localparam int CMP_W = 17;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_CHECK = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ZERO_SIZE = 3'd1,
		ST_NO_ROW    = 3'd2,
		ST_NO_FIT    = 3'd3,
		ST_NO_OWNER  = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_OWN_RD,
		S_OWN_CK,
		S_FREE_ROW,
		S_FIT_RD,
		S_FIT_CK,
		S_DROP_RD,
		S_DROP_WR,
		S_POS_RD,
		S_POS_CK,
		S_MERGE,
		S_UP_RD,
		S_UP_WR,
		S_FINISH
	} fsm_t;

endpackage
`default_nettype wire

// ===== src/first_fit_partition_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   signals                                   handshake
// command   cmd, owner_id, req_size, address          start & !busy
// result    ok, status, base, holes_created           done (one-cycle strobe)
//
// Steps: a command walks the row table, looking for its owner or for a free row,
// then the hole table hole by hole, then may shift holes up or down one entry at
// a time, each step paced by the single read port of each table. Reset frees
// every row and leaves one hole covering all memory, with no clearing pass. busy
// is high from the accepting edge until done pulses; the receiver cannot stall,
// so done is high for exactly one cycle per result.
module first_fit_partition_allocator #(
	parameter int MEM_WORDS  = ffpa_pkg::MEM_WORDS_DEF,
	parameter int TABLE_ROWS = ffpa_pkg::TABLE_ROWS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [1:0]                   cmd,
	input  wire logic [15:0]                  owner_id,
	input  wire logic [15:0]                  req_size,
	input  wire logic [15:0]                  address,
	output logic                              done,
	output logic                              ok,
	output logic [2:0]                        status,
	output logic [$clog2(MEM_WORDS)-1:0]      base,
	output logic [31:0]                       holes_created
);

	localparam int AW  = $clog2(MEM_WORDS);
	localparam int SW  = $clog2(MEM_WORDS) + 1;
	localparam int RI  = $clog2(TABLE_ROWS);
	localparam int RCW = $clog2(TABLE_ROWS + 1);
	localparam int HD  = TABLE_ROWS + 1;
	localparam int HI  = $clog2(HD);
	localparam int HCW = $clog2(HD + 1);
	localparam int CW  = ffpa_pkg::CMP_W;

	ffpa_pkg::fsm_t state_q, state_d;

	// captured command
	ffpa_pkg::cmd_t cmd_q;
	logic [15:0]    who_q;
	logic [15:0]    req_q;
	logic [15:0]    addr_q;

	// scan indexes and hole count
	logic [RCW-1:0] ri_q;
	logic [HCW-1:0] k_q;
	logic [HCW-1:0] pos_q;
	logic [HCW-1:0] cnt_q;
	logic [31:0]    created_q;

	// region being freed and its neighbor holes
	logic [AW-1:0]  fb_q;
	logic [SW-1:0]  fs_q;
	logic [AW-1:0]  lb_q;
	logic [SW-1:0]  ls_q;
	logic [AW-1:0]  rb_q;
	logic [SW-1:0]  rs_q;
	logic           hl_q;
	logic           hr_q;

	// result beat
	logic           ok_q;
	logic [2:0]     st_q;
	logic [AW-1:0]  base_q;
	logic           done_q;

	// table ports
	logic [15:0]   row_owner;
	logic [AW-1:0] row_base;
	logic [SW-1:0] row_size;
	logic          row_used;
	logic          row_wr;
	logic          row_clr;
	logic [HI-1:0] h_rd_idx;
	logic [AW-1:0] h_rd_base;
	logic [SW-1:0] h_rd_size;
	logic          h_wr;
	logic [HI-1:0] h_wr_idx;
	logic [AW-1:0] h_wr_base;
	logic [SW-1:0] h_wr_size;

	// shared compare terms
	logic          owner_hit;
	logic          fits;
	logic          exact;
	logic          left_merge;
	logic          right_merge;
	logic          in_range;
	logic [CW-1:0] free_end;

	ffpa_row_mem #(.TABLE_ROWS(TABLE_ROWS), .AW(AW), .SW(SW)) u_rows (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (ri_q[RI-1:0]),
		.rd_owner (row_owner),
		.rd_base  (row_base),
		.rd_size  (row_size),
		.wr_en    (row_wr),
		.wr_idx   (ri_q[RI-1:0]),
		.wr_owner (who_q),
		.wr_base  (h_rd_base),
		.wr_size  (SW'(req_q)),
		.clr_en   (row_clr),
		.clr_idx  (ri_q[RI-1:0]),
		.used_idx (ri_q[RI-1:0]),
		.used_bit (row_used)
	);

	ffpa_hole_mem #(.DEPTH(HD), .MEM_WORDS(MEM_WORDS), .AW(AW), .SW(SW)) u_holes (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (h_rd_idx),
		.rd_base (h_rd_base),
		.rd_size (h_rd_size),
		.wr_en   (h_wr),
		.wr_idx  (h_wr_idx),
		.wr_base (h_wr_base),
		.wr_size (h_wr_size)
	);

	assign owner_hit   = row_used && (row_owner == who_q);
	assign fits        = CW'(h_rd_size) >= CW'(req_q);
	assign exact       = CW'(h_rd_size) == CW'(req_q);
	assign free_end    = CW'(fb_q) + CW'(fs_q);
	// a full hole table drops the freed region, so nothing merges then
	assign left_merge  = hl_q && (cnt_q < HCW'(HD)) &&
	                     ((CW'(lb_q) + CW'(ls_q)) == CW'(fb_q));
	assign right_merge = hr_q && (cnt_q < HCW'(HD)) && (free_end == CW'(rb_q));
	assign in_range    = (CW'(addr_q) >= CW'(row_base)) &&
	                     (CW'(addr_q) < (CW'(row_base) + CW'(row_size)));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ffpa_pkg::S_IDLE: begin
				if (start) begin
					if (ffpa_pkg::cmd_t'(cmd) != ffpa_pkg::CMD_ALLOC)
						state_d = ffpa_pkg::S_OWN_RD;
					else if (req_size == '0)
						state_d = ffpa_pkg::S_FINISH;
					else
						state_d = ffpa_pkg::S_FREE_ROW;
				end
			end
			ffpa_pkg::S_OWN_RD: begin
				state_d = (ri_q == RCW'(TABLE_ROWS)) ? ffpa_pkg::S_FINISH
				                                     : ffpa_pkg::S_OWN_CK;
			end
			ffpa_pkg::S_OWN_CK: begin
				if (!owner_hit)
					state_d = ffpa_pkg::S_OWN_RD;
				else if (cmd_q == ffpa_pkg::CMD_FREE)
					state_d = ffpa_pkg::S_POS_RD;
				else
					state_d = ffpa_pkg::S_FINISH;
			end
			ffpa_pkg::S_FREE_ROW: begin
				if (ri_q == RCW'(TABLE_ROWS))
					state_d = ffpa_pkg::S_FINISH;
				else if (!row_used)
					state_d = ffpa_pkg::S_FIT_RD;
			end
			ffpa_pkg::S_FIT_RD: begin
				state_d = (k_q == cnt_q) ? ffpa_pkg::S_FINISH : ffpa_pkg::S_FIT_CK;
			end
			ffpa_pkg::S_FIT_CK: begin
				if (!fits)
					state_d = ffpa_pkg::S_FIT_RD;
				else if (exact)
					state_d = ffpa_pkg::S_DROP_RD;
				else
					state_d = ffpa_pkg::S_FINISH;
			end
			ffpa_pkg::S_DROP_RD: begin
				state_d = ((k_q + 1'b1) < cnt_q) ? ffpa_pkg::S_DROP_WR
				                                 : ffpa_pkg::S_FINISH;
			end
			ffpa_pkg::S_DROP_WR: state_d = ffpa_pkg::S_DROP_RD;
			ffpa_pkg::S_POS_RD: begin
				state_d = (k_q == cnt_q) ? ffpa_pkg::S_MERGE : ffpa_pkg::S_POS_CK;
			end
			ffpa_pkg::S_POS_CK: begin
				state_d = (h_rd_base < fb_q) ? ffpa_pkg::S_POS_RD : ffpa_pkg::S_MERGE;
			end
			ffpa_pkg::S_MERGE: begin
				if (left_merge && right_merge)
					state_d = ffpa_pkg::S_DROP_RD;
				else if (left_merge || right_merge)
					state_d = ffpa_pkg::S_FINISH;
				else if (cnt_q < HCW'(HD))
					state_d = ffpa_pkg::S_UP_RD;
				else
					state_d = ffpa_pkg::S_FINISH;
			end
			ffpa_pkg::S_UP_RD: begin
				state_d = (k_q > pos_q) ? ffpa_pkg::S_UP_WR : ffpa_pkg::S_FINISH;
			end
			ffpa_pkg::S_UP_WR: state_d = ffpa_pkg::S_UP_RD;
			ffpa_pkg::S_FINISH: state_d = ffpa_pkg::S_IDLE;
			default: state_d = ffpa_pkg::S_IDLE;
		endcase
	end

	// table control
	always_comb begin
		row_wr    = 1'b0;
		row_clr   = 1'b0;
		h_wr      = 1'b0;
		h_wr_idx  = k_q[HI-1:0];
		h_wr_base = h_rd_base;
		h_wr_size = h_rd_size;
		case (state_q)
			ffpa_pkg::S_DROP_RD: h_rd_idx = HI'(k_q + 1'b1);
			ffpa_pkg::S_UP_RD:   h_rd_idx = HI'(k_q - 1'b1);
			default:             h_rd_idx = k_q[HI-1:0];
		endcase
		case (state_q)
			ffpa_pkg::S_OWN_CK: begin
				row_clr = owner_hit && (cmd_q == ffpa_pkg::CMD_FREE);
			end
			ffpa_pkg::S_FIT_CK: begin
				// cut the block from the front of the hole
				row_wr    = fits;
				h_wr      = fits && !exact;
				h_wr_base = AW'(CW'(h_rd_base) + CW'(req_q));
				h_wr_size = SW'(CW'(h_rd_size) - CW'(req_q));
			end
			ffpa_pkg::S_DROP_WR: h_wr = 1'b1;
			ffpa_pkg::S_UP_WR:   h_wr = 1'b1;
			ffpa_pkg::S_MERGE: begin
				if (left_merge) begin
					h_wr      = 1'b1;
					h_wr_idx  = HI'(pos_q - 1'b1);
					h_wr_base = lb_q;
					h_wr_size = right_merge ? SW'(CW'(ls_q) + CW'(fs_q) + CW'(rs_q))
					                        : SW'(CW'(ls_q) + CW'(fs_q));
				end else if (right_merge) begin
					h_wr      = 1'b1;
					h_wr_idx  = pos_q[HI-1:0];
					h_wr_base = fb_q;
					h_wr_size = SW'(CW'(fs_q) + CW'(rs_q));
				end
			end
			ffpa_pkg::S_UP_RD: begin
				// shifting done: drop the freed region into its slot
				if (k_q <= pos_q) begin
					h_wr      = 1'b1;
					h_wr_idx  = pos_q[HI-1:0];
					h_wr_base = fb_q;
					h_wr_size = fs_q;
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ffpa_pkg::S_IDLE;
			ri_q      <= '0;
			k_q       <= '0;
			pos_q     <= '0;
			cnt_q     <= HCW'(1);
			created_q <= '0;
			done_q    <= 1'b0;
			hl_q      <= 1'b0;
			hr_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ffpa_pkg::S_FINISH);
			case (state_q)
				ffpa_pkg::S_IDLE: begin
					ri_q <= '0;
					k_q  <= '0;
					hl_q <= 1'b0;
					hr_q <= 1'b0;
				end
				ffpa_pkg::S_OWN_CK: begin
					if (!owner_hit)
						ri_q <= ri_q + 1'b1;
					else if (cmd_q == ffpa_pkg::CMD_FREE)
						created_q <= created_q + 1'b1;
				end
				ffpa_pkg::S_FREE_ROW: begin
					if (row_used)
						ri_q <= ri_q + 1'b1;
				end
				ffpa_pkg::S_FIT_CK: begin
					if (!fits)
						k_q <= k_q + 1'b1;
				end
				ffpa_pkg::S_DROP_RD: begin
					if (!((k_q + 1'b1) < cnt_q))
						cnt_q <= cnt_q - 1'b1;
				end
				ffpa_pkg::S_DROP_WR: k_q <= k_q + 1'b1;
				ffpa_pkg::S_POS_RD: pos_q <= k_q;
				ffpa_pkg::S_POS_CK: begin
					if (h_rd_base < fb_q) begin
						hl_q <= 1'b1;
						k_q  <= k_q + 1'b1;
					end else begin
						hr_q <= 1'b1;
					end
				end
				ffpa_pkg::S_MERGE: begin
					// both neighbors touch: drop the right one after widening the left
					if (left_merge && right_merge)
						k_q <= pos_q;
					else
						k_q <= cnt_q;
				end
				ffpa_pkg::S_UP_RD: begin
					if (!(k_q > pos_q))
						cnt_q <= cnt_q + 1'b1;
				end
				ffpa_pkg::S_UP_WR: k_q <= k_q - 1'b1;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ffpa_pkg::S_IDLE: begin
				if (start) begin
					cmd_q  <= ffpa_pkg::cmd_t'(cmd);
					who_q  <= owner_id;
					req_q  <= req_size;
					addr_q <= address;
					ok_q   <= 1'b0;
					base_q <= '0;
					st_q   <= (ffpa_pkg::cmd_t'(cmd) == ffpa_pkg::CMD_ALLOC &&
					           req_size == '0) ? ffpa_pkg::ST_ZERO_SIZE
					                           : ffpa_pkg::ST_OK;
				end
			end
			ffpa_pkg::S_OWN_RD: begin
				if (ri_q == RCW'(TABLE_ROWS))
					st_q <= ffpa_pkg::ST_NO_OWNER;
			end
			ffpa_pkg::S_OWN_CK: begin
				if (owner_hit) begin
					fb_q <= row_base;
					fs_q <= row_size;
					case (cmd_q)
						ffpa_pkg::CMD_FREE: ok_q <= 1'b1;
						ffpa_pkg::CMD_QUERY: begin
							ok_q   <= 1'b1;
							base_q <= row_base;
						end
						ffpa_pkg::CMD_CHECK: ok_q <= in_range;
						default: ;
					endcase
				end
			end
			ffpa_pkg::S_FREE_ROW: begin
				if (ri_q == RCW'(TABLE_ROWS))
					st_q <= ffpa_pkg::ST_NO_ROW;
			end
			ffpa_pkg::S_FIT_RD: begin
				if (k_q == cnt_q)
					st_q <= ffpa_pkg::ST_NO_FIT;
			end
			ffpa_pkg::S_FIT_CK: begin
				if (fits) begin
					ok_q   <= 1'b1;
					base_q <= h_rd_base;
				end
			end
			ffpa_pkg::S_POS_CK: begin
				if (h_rd_base < fb_q) begin
					lb_q <= h_rd_base;
					ls_q <= h_rd_size;
				end else begin
					rb_q <= h_rd_base;
					rs_q <= h_rd_size;
				end
			end
			default: ;
		endcase
	end

	assign busy          = (state_q != ffpa_pkg::S_IDLE);
	assign done          = done_q;
	assign ok            = ok_q;
	assign status        = st_q;
	assign base          = base_q;
	assign holes_created = created_q;

endmodule
`default_nettype wire

// ===== src/ffpa_row_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ffpa_row_mem #(
	parameter int TABLE_ROWS = ffpa_pkg::TABLE_ROWS_DEF,
	parameter int AW = 10,
	parameter int SW = 11
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [$clog2(TABLE_ROWS)-1:0] rd_idx,
	output logic [15:0]                        rd_owner,
	output logic [AW-1:0]                      rd_base,
	output logic [SW-1:0]                      rd_size,
	input  wire logic                          wr_en,
	input  wire logic [$clog2(TABLE_ROWS)-1:0] wr_idx,
	input  wire logic [15:0]                   wr_owner,
	input  wire logic [AW-1:0]                 wr_base,
	input  wire logic [SW-1:0]                 wr_size,
	input  wire logic                          clr_en,
	input  wire logic [$clog2(TABLE_ROWS)-1:0] clr_idx,
	input  wire logic [$clog2(TABLE_ROWS)-1:0] used_idx,
	output logic                               used_bit
);

	logic [15:0]         owner_mem [TABLE_ROWS];
	logic [AW-1:0]       base_mem  [TABLE_ROWS];
	logic [SW-1:0]       size_mem  [TABLE_ROWS];
	logic [TABLE_ROWS-1:0] used_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			owner_mem[wr_idx] <= wr_owner;
			base_mem[wr_idx]  <= wr_base;
			size_mem[wr_idx]  <= wr_size;
		end
		rd_owner <= owner_mem[rd_idx];
		rd_base  <= base_mem[rd_idx];
		rd_size  <= size_mem[rd_idx];
	end

	// a row is live only while its used bit is set; reset frees every row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			if (wr_en)
				used_q[wr_idx] <= 1'b1;
			if (clr_en)
				used_q[clr_idx] <= 1'b0;
		end
	end

	assign used_bit = used_q[used_idx];

endmodule
`default_nettype wire

// ===== src/ffpa_hole_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ffpa_hole_mem #(
	parameter int DEPTH = ffpa_pkg::TABLE_ROWS_DEF + 1,
	parameter int MEM_WORDS = ffpa_pkg::MEM_WORDS_DEF,
	parameter int AW = 10,
	parameter int SW = 11
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [$clog2(DEPTH)-1:0] rd_idx,
	output logic [AW-1:0]                 rd_base,
	output logic [SW-1:0]                 rd_size,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_idx,
	input  wire logic [AW-1:0]            wr_base,
	input  wire logic [SW-1:0]            wr_size
);

	logic [AW-1:0] base_mem [DEPTH];
	logic [SW-1:0] size_mem [DEPTH];
	logic [AW-1:0] base_rd_q;
	logic [SW-1:0] size_rd_q;
	logic          init0_q;
	logic          hit0_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			base_mem[wr_idx] <= wr_base;
			size_mem[wr_idx] <= wr_size;
		end
		base_rd_q <= base_mem[rd_idx];
		size_rd_q <= size_mem[rd_idx];
	end

	// entry 0 reads as one hole over all memory until it is first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init0_q <= 1'b0;
			hit0_q  <= 1'b0;
		end else begin
			hit0_q <= (rd_idx == '0) && !init0_q;
			if (wr_en && (wr_idx == '0))
				init0_q <= 1'b1;
		end
	end

	assign rd_base = hit0_q ? '0 : base_rd_q;
	assign rd_size = hit0_q ? SW'(MEM_WORDS) : size_rd_q;

endmodule
`default_nettype wire
